[sv/assert_macros.svh]
// Assertion macros shared by the relocation patcher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[sv/rfp_pkg.sv]
// Types, codes, constants and bit-scatter functions of the relocation patcher
`default_nettype none

package rfp_pkg;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [31:0] STUB_W0_BASE = 32'h2020_0000;
    localparam logic [31:0] STUB_W1_BASE = 32'he020_2002;
    localparam logic [31:0] MASK_L21     = 32'h001f_ffff;
    localparam logic [31:0] MASK_R14     = 32'h0000_3fff;
    localparam logic [31:0] MASK_BR17    = 32'h001f_1ffd;
    localparam logic [31:0] MASK_BR22    = 32'h03ff_1ffd;
    localparam logic [31:0] ROUND_HALF   = 32'h0000_1000;

    typedef enum logic [3:0] {
        MODE_PLABEL32 = 4'd0,
        MODE_DIR32    = 4'd1,
        MODE_DIR21L   = 4'd2,
        MODE_DIR14R   = 4'd3,
        MODE_SEGREL32 = 4'd4,
        MODE_DPREL21L = 4'd5,
        MODE_DPREL14R = 4'd6,
        MODE_PCREL17F = 4'd7,
        MODE_PCREL22F = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        REG_SECTION_BASE = 2'd0,
        REG_STUB_BUDGET  = 2'd1,
        REG_DATA_POINTER = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDEF   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_EXHAUST = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        K_ABS,
        K_L21,
        K_R14,
        K_BR17,
        K_BR22,
        K_UNDEF,
        K_UNKNOWN
    } kind_t;

    // Classified word between front and back
    typedef struct packed {
        kind_t        kind;
        logic [31:0]  sum;        // symbol + addend
        logic [20:0]  lsum_hi;    // left part (rounded)
        logic [18:0]  right;      // right part, low bits
        logic [29:0]  disp;       // direct branch displacement, words
        logic [29:0]  stub_disp;  // displacement to stub slot 0, words
        logic [31:0]  old_word;
    } mid_entry_t;

    // Section setup seen by the back end
    typedef struct packed {
        logic [28:0]  start_word; // stub area start, 8-byte units
        logic [15:0]  stub_budget;
        logic         clear_used;
    } back_cfg_t;

    typedef struct packed {
        logic [31:0]  new_word;
        logic         stub_made;
        logic [31:0]  stub_addr;
        logic [31:0]  stub_word_first;
        logic [31:0]  stub_word_second;
        status_t      status;
    } result_t;

    function automatic logic [13:0] scatter14(input logic [13:0] x);
        return {x[12:0], x[13]};
    endfunction

    function automatic logic [31:0] scatter17(input logic [16:0] x);
        logic [31:0] r;
        r        = '0;
        r[0]     = x[16];
        r[20:16] = x[15:11];
        r[2]     = x[10];
        r[12:3]  = x[9:0];
        return r;
    endfunction

    function automatic logic [31:0] scatter21(input logic [20:0] x);
        logic [31:0] r;
        r        = '0;
        r[0]     = x[20];
        r[11:1]  = x[19:9];
        r[15:14] = x[8:7];
        r[20:16] = x[6:2];
        r[13:12] = x[1:0];
        return r;
    endfunction

    function automatic logic [31:0] scatter22(input logic [21:0] x);
        logic [31:0] r;
        r        = '0;
        r[0]     = x[21];
        r[25:21] = x[20:16];
        r[20:16] = x[15:11];
        r[2]     = x[10];
        r[12:3]  = x[9:0];
        return r;
    endfunction

    // Signed range checks on a 30-bit word displacement
    function automatic logic fits17(input logic [29:0] d);
        return (d[29:16] == '0) || (d[29:16] == '1);
    endfunction

    function automatic logic fits22(input logic [29:0] d);
        return (d[29:21] == '0) || (d[29:21] == '1);
    endfunction

endpackage

`default_nettype wire

[sv/rfp_queue.sv]
// Small register FIFO used between front and back and at the result side
`default_nettype none
`include "assert_macros.svh"

module rfp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_FULL)
    `ASSERT_NEXT(a_cnt_grow, clk, rst_n, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

`default_nettype wire

[sv/rfp_front.sv]
// Front end: config registers, input stage, classification and address math
`default_nettype none
`include "assert_macros.svh"

module rfp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [3:0]          mode,
    input  logic [31:0]         symbol_value,
    input  logic signed [31:0]  addend,
    input  logic [31:0]         place_addr,
    input  logic [31:0]         old_word,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [31:0]         wr_data,
    output logic                mid_push,
    output rfp_pkg::mid_entry_t mid_data,
    input  logic                mid_full,
    output rfp_pkg::back_cfg_t  bcfg
);

    import rfp_pkg::*;

    logic [31:0] section_base_reg, section_base_next;
    logic [15:0] stub_budget_reg, stub_budget_next;
    logic [31:0] data_pointer_reg, data_pointer_next;
    logic [28:0] start_reg, start_next;

    logic        s1_valid_reg, s1_valid_next;
    kind_t       s1_kind_reg, s1_kind_next;
    logic [31:0] s1_sum_reg, s1_sum_next;
    logic [31:0] s1_v_reg, s1_v_next;
    logic [18:0] s1_rhi_reg, s1_rhi_next;
    logic [12:0] s1_alo_reg, s1_alo_next;
    logic [29:0] s1_pword_reg, s1_pword_next;
    logic [31:0] s1_old_reg, s1_old_next;

    logic        s1_adv, accept;
    logic [31:0] add_u, rnd, lsum;
    logic [18:0] right;

    // Config writes
    always_comb
    begin
        section_base_next = section_base_reg;
        stub_budget_next  = stub_budget_reg;
        data_pointer_next = data_pointer_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SECTION_BASE: section_base_next = wr_data;
                REG_STUB_BUDGET:  stub_budget_next  = wr_data[15:0];
                REG_DATA_POINTER: data_pointer_next = wr_data;
                default:          ;
            endcase
        end
        // stub area start, rounded up to 8 bytes, budget plus one slots below the section base
        start_next = section_base_reg[31:3] + 29'(section_base_reg[2:0] != 3'b0)
                   - 29'(stub_budget_reg) - 29'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_base_reg <= '0;
            stub_budget_reg  <= '0;
            data_pointer_reg <= '0;
            start_reg        <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            section_base_reg <= section_base_next;
            stub_budget_reg  <= stub_budget_next;
            data_pointer_reg <= data_pointer_next;
            start_reg        <= start_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    assign bcfg.start_word  = start_reg;
    assign bcfg.stub_budget = stub_budget_reg;
    assign bcfg.clear_used  = wr_en && (wr_index == REG_SECTION_BASE ||
                                        wr_index == REG_STUB_BUDGET);

    // Stage 1: classify and first-level sums
    assign s1_adv = !s1_valid_reg || !mid_full;
    assign full   = !s1_adv;
    assign accept = push && s1_adv;
    assign add_u  = $unsigned(addend);
    assign rnd    = add_u + ROUND_HALF;

    always_comb
    begin
        s1_valid_next = s1_adv ? accept : s1_valid_reg;
        s1_sum_next   = symbol_value + add_u;
        s1_rhi_next   = rnd[31:13];
        s1_alo_next   = add_u[12:0];
        s1_pword_next = place_addr[31:2] + 30'd2;
        s1_old_next   = old_word;
        s1_v_next     = (mode == MODE_DPREL21L || mode == MODE_DPREL14R)
                      ? symbol_value - data_pointer_reg : symbol_value;
        if (symbol_value == '0)
        begin
            s1_kind_next = K_UNDEF;
        end
        else
        begin
            case (mode)
                MODE_PLABEL32, MODE_DIR32, MODE_SEGREL32: s1_kind_next = K_ABS;
                MODE_DIR21L, MODE_DPREL21L:               s1_kind_next = K_L21;
                MODE_DIR14R, MODE_DPREL14R:               s1_kind_next = K_R14;
                MODE_PCREL17F:                            s1_kind_next = K_BR17;
                MODE_PCREL22F:                            s1_kind_next = K_BR22;
                default:                                  s1_kind_next = K_UNKNOWN;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= s1_kind_next;
            s1_sum_reg   <= s1_sum_next;
            s1_v_reg     <= s1_v_next;
            s1_rhi_reg   <= s1_rhi_next;
            s1_alo_reg   <= s1_alo_next;
            s1_pword_reg <= s1_pword_next;
            s1_old_reg   <= s1_old_next;
        end
    end

    // Stage 2 (into queue): left/right split and displacements
    assign lsum  = s1_v_reg + {s1_rhi_reg, 13'b0};
    // addend minus rounded addend is the sign-extended low 13 bits
    assign right = {8'b0, lsum[10:0]} + {{6{s1_alo_reg[12]}}, s1_alo_reg};

    assign mid_push           = s1_valid_reg && !mid_full;
    assign mid_data.kind      = s1_kind_reg;
    assign mid_data.sum       = s1_sum_reg;
    assign mid_data.lsum_hi   = lsum[31:11];
    assign mid_data.right     = right;
    assign mid_data.disp      = s1_sum_reg[31:2] - s1_pword_reg;
    assign mid_data.stub_disp = {start_reg, 1'b0} - s1_pword_reg;
    assign mid_data.old_word  = s1_old_reg;

    `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && mid_full, s1_valid_reg)

endmodule

`default_nettype wire

[sv/rfp_back.sv]
// Back end: stub slot allocation, branch retargeting and word patching
`default_nettype none
`include "assert_macros.svh"

module rfp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rfp_pkg::back_cfg_t  bcfg,
    input  logic                mid_empty,
    input  rfp_pkg::mid_entry_t mid_data,
    output logic                mid_pop,
    input  logic                out_full,
    output logic                out_push,
    output rfp_pkg::result_t    out_data
);

    import rfp_pkg::*;

    logic [15:0] used_reg, used_next;
    logic        fire, is17, fit_d, fit_s, need, exhausted, alloc;
    logic [29:0] sd, bd;
    logic [28:0] slot_word;
    logic [31:0] w0, w1;

    assign fire      = !mid_empty && !out_full;
    assign mid_pop   = fire;
    assign out_push  = fire;

    assign is17      = (mid_data.kind == K_BR17);
    assign fit_d     = is17 ? fits17(mid_data.disp) : fits22(mid_data.disp);
    assign need      = (mid_data.kind == K_BR17 || mid_data.kind == K_BR22) && !fit_d;
    assign exhausted = (used_reg >= bcfg.stub_budget);
    assign alloc     = need && !exhausted;

    // each slot is two words
    assign sd        = mid_data.stub_disp + 30'({used_reg, 1'b0});
    assign fit_s     = is17 ? fits17(sd) : fits22(sd);
    assign bd        = need ? sd : mid_data.disp;
    assign slot_word = bcfg.start_word + 29'(used_reg);
    assign w0        = STUB_W0_BASE | scatter21(mid_data.lsum_hi);
    assign w1        = STUB_W1_BASE | scatter17(mid_data.right[18:2]);

    always_comb
    begin
        out_data.new_word         = mid_data.old_word;
        out_data.stub_made        = 1'b0;
        out_data.stub_addr        = '0;
        out_data.stub_word_first  = '0;
        out_data.stub_word_second = '0;
        out_data.status           = ST_OK;
        case (mid_data.kind)
            K_ABS:
            begin
                out_data.new_word = mid_data.sum;
            end
            K_L21:
            begin
                out_data.new_word = (mid_data.old_word & ~MASK_L21)
                                  | scatter21(mid_data.lsum_hi);
            end
            K_R14:
            begin
                out_data.new_word = (mid_data.old_word & ~MASK_R14)
                                  | {18'b0, scatter14(mid_data.right[13:0])};
            end
            K_BR17, K_BR22:
            begin
                if (need && exhausted)
                begin
                    out_data.status = ST_EXHAUST;
                end
                else
                begin
                    if (alloc)
                    begin
                        out_data.stub_made        = 1'b1;
                        out_data.stub_addr        = {slot_word, 3'b0};
                        out_data.stub_word_first  = w0;
                        out_data.stub_word_second = w1;
                    end
                    if (alloc && !fit_s)
                    begin
                        out_data.status = ST_RANGE;
                    end
                    else if (is17)
                    begin
                        out_data.new_word = (mid_data.old_word & ~MASK_BR17)
                                          | scatter17(bd[16:0]);
                    end
                    else
                    begin
                        out_data.new_word = (mid_data.old_word & ~MASK_BR22)
                                          | scatter22(bd[21:0]);
                    end
                end
            end
            K_UNDEF:
            begin
                out_data.status = ST_UNDEF;
            end
            default:
            begin
                out_data.status = ST_UNKNOWN;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        if (bcfg.clear_used)
        begin
            used_next = '0;
        end
        else if (fire && alloc)
        begin
            used_next = used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    `ASSERT_NEXT(a_used_step, clk, rst_n, fire && alloc && !bcfg.clear_used, used_reg == $past(used_reg) + 1'b1)
    `ASSERT_IMPL(a_made_status, clk, rst_n, out_data.stub_made, out_data.status == ST_OK || out_data.status == ST_RANGE)

endmodule

`default_nettype wire

[sv/relocation_field_patcher.sv]
// Top level of the relocation field patcher: front, queues and back wired together
//
//   channel   handshake          payload
//   -------   ----------------   --------------------------------------------------
//   input     push / full        mode symbol_value addend place_addr old_word
//   result    pop / empty        new_word stub_made stub_addr stub_word_first
//                                stub_word_second status
//   config    wr_en              wr_index wr_data (0 base, 1 budget, 2 data ptr)
//
// One word per cycle sustained while the result side keeps popping; an accepted word
// goes through the input stage, middle queue and result queue before it can be popped.
// The back end's stub slot counter is the only state carried from word to word and
// is updated in the same cycle the word leaves the middle queue.
// Reset (rst_n low) clears the config registers, slot counter and both queues.
// Either side may stall freely; the queues absorb up to their depth of words.
`default_nettype none

module relocation_field_patcher #(
    parameter int MID_DEPTH = rfp_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = rfp_pkg::OUT_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         mode,
    input  logic [31:0]        symbol_value,
    input  logic signed [31:0] addend,
    input  logic [31:0]        place_addr,
    input  logic [31:0]        old_word,
    input  logic               pop,
    output logic               empty,
    output logic [31:0]        new_word,
    output logic               stub_made,
    output logic [31:0]        stub_addr,
    output logic [31:0]        stub_word_first,
    output logic [31:0]        stub_word_second,
    output logic [2:0]         status,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data
);

    import rfp_pkg::*;

    mid_entry_t mid_in, mid_out;
    back_cfg_t  bcfg;
    result_t    res_in, res_out;
    logic       mid_push, mid_full, mid_pop, mid_empty;
    logic       out_push, out_full;

    rfp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .symbol_value (symbol_value),
        .addend       (addend),
        .place_addr   (place_addr),
        .old_word     (old_word),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .mid_push     (mid_push),
        .mid_data     (mid_in),
        .mid_full     (mid_full),
        .bcfg         (bcfg)
    );

    rfp_queue #(
        .WIDTH ($bits(mid_entry_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .full  (mid_full),
        .wdata (mid_in),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (mid_out)
    );

    rfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bcfg      (bcfg),
        .mid_empty (mid_empty),
        .mid_data  (mid_out),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (res_in)
    );

    rfp_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .full  (out_full),
        .wdata (res_in),
        .pop   (pop),
        .empty (empty),
        .rdata (res_out)
    );

    assign new_word         = res_out.new_word;
    assign stub_made        = res_out.stub_made;
    assign stub_addr        = res_out.stub_addr;
    assign stub_word_first  = res_out.stub_word_first;
    assign stub_word_second = res_out.stub_word_second;
    assign status           = res_out.status;

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for relocation_field_patcher: directed and random relocations, scoreboarded
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfp_pkg::*;

    localparam int          PIPE_LATENCY = 3;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam logic [1:0]  REG_RESERVED = 2'd3;

    typedef struct {
        logic [3:0]         mode;
        logic [31:0]        symbol;
        logic signed [31:0] addend;
        logic [31:0]        place;
        logic [31:0]        old_word;
    } reloc_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [3:0]         mode = '0;
    logic [31:0]        symbol_value = '0;
    logic signed [31:0] addend = '0;
    logic [31:0]        place_addr = '0;
    logic [31:0]        old_word = '0;
    logic               pop = 1'b0;
    logic               empty;
    logic [31:0]        new_word;
    logic               stub_made;
    logic [31:0]        stub_addr;
    logic [31:0]        stub_word_first;
    logic [31:0]        stub_word_second;
    logic [2:0]         status;
    logic               wr_en = 1'b0;
    logic [1:0]         wr_index = '0;
    logic [31:0]        wr_data = '0;

    relocation_field_patcher u_top (.*);

    // Shadow of the block's registers and slot counter
    logic [31:0] base_reg;
    logic [15:0] budget_reg;
    logic [31:0] dp_reg;
    logic [15:0] stubs_taken;

    result_t     expected_q[$];
    int          error_count;
    int          cycle_count;
    int          status_tally[5];
    int          stub_tally;
    int          setup_count;
    bit          tx_idle_en;
    bit          rx_idle_en;
    bit          rx_hold_req;
    int          rx_hold_left;
    int          rx_stall_left;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d words pending", cycle_count, expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- prediction ----------------

    function automatic logic [31:0] round_part(input logic [31:0] a);
        return (a + ROUND_HALF) & ~32'h0000_1fff;
    endfunction

    function automatic logic [31:0] left_part(input logic [31:0] v, input logic [31:0] a);
        return (v + round_part(a)) >> 11;
    endfunction

    function automatic logic [31:0] right_part(input logic [31:0] v, input logic [31:0] a);
        logic [31:0] rnd;
        rnd = round_part(a);
        return ((v + rnd) & 32'h0000_07ff) + (a - rnd);
    endfunction

    function automatic logic [31:0] spread14(input logic [31:0] x);
        return ((x & 32'h1fff) << 1) | ((x & 32'h2000) >> 13);
    endfunction

    function automatic logic [31:0] spread17(input logic [31:0] x);
        return ((x & 32'h10000) >> 16) | ((x & 32'h0f800) << 5) |
               ((x & 32'h00400) >> 8) | ((x & 32'h003ff) << 3);
    endfunction

    function automatic logic [31:0] spread21(input logic [31:0] x);
        return ((x & 32'h100000) >> 20) | ((x & 32'h0ffe00) >> 8) |
               ((x & 32'h000180) << 7) | ((x & 32'h00007c) << 14) |
               ((x & 32'h000003) << 12);
    endfunction

    function automatic logic [31:0] spread22(input logic [31:0] x);
        return ((x & 32'h200000) >> 21) | ((x & 32'h1f0000) << 5) |
               ((x & 32'h00f800) << 5) | ((x & 32'h000400) >> 8) |
               ((x & 32'h0003ff) << 3);
    endfunction

    function automatic logic [31:0] word_disp(input logic [31:0] target, input logic [31:0] place);
        return (target - (place & ~32'd3) - 32'd8) >> 2;
    endfunction

    // 30-bit displacement must sign-extend from bit width-1
    function automatic bit in_reach(input logic [31:0] d, input int unsigned width);
        logic [31:0] upper;
        upper = d >> (width - 1);
        return (upper == 32'd0) || (upper == (32'h3fff_ffff >> (width - 1)));
    endfunction

    function automatic result_t relocate_word(input reloc_t r);
        result_t     res;
        logic [31:0] sum;
        logic [31:0] v;
        logic [31:0] d;
        logic [31:0] area_start;
        int unsigned width;
        res = '0;
        res.new_word = r.old_word;
        res.status = ST_OK;
        sum = r.symbol + r.addend;
        if (r.symbol == 32'd0)
            res.status = ST_UNDEF;
        else
        begin
            case (r.mode)
                MODE_PLABEL32, MODE_DIR32, MODE_SEGREL32:
                    res.new_word = sum;
                MODE_DIR21L, MODE_DPREL21L:
                begin
                    v = (r.mode == MODE_DPREL21L) ? r.symbol - dp_reg : r.symbol;
                    res.new_word = (r.old_word & ~MASK_L21) | spread21(left_part(v, r.addend));
                end
                MODE_DIR14R, MODE_DPREL14R:
                begin
                    v = (r.mode == MODE_DPREL14R) ? r.symbol - dp_reg : r.symbol;
                    res.new_word = (r.old_word & ~MASK_R14) | spread14(right_part(v, r.addend));
                end
                MODE_PCREL17F, MODE_PCREL22F:
                begin
                    width = (r.mode == MODE_PCREL17F) ? 17 : 22;
                    d = word_disp(sum, r.place);
                    if (!in_reach(d, width))
                    begin
                        if (stubs_taken >= budget_reg)
                            res.status = ST_EXHAUST;
                        else
                        begin
                            area_start = base_reg - (({16'd0, budget_reg} + 32'd1) << 3);
                            area_start = (area_start + 32'd7) & ~32'd7;
                            res.stub_addr = area_start + {13'd0, stubs_taken, 3'b000};
                            stubs_taken = stubs_taken + 16'd1;
                            res.stub_made = 1'b1;
                            res.stub_word_first = STUB_W0_BASE |
                                                  spread21(left_part(r.symbol, r.addend));
                            res.stub_word_second = STUB_W1_BASE |
                                                   spread17(right_part(r.symbol, r.addend) >> 2);
                            d = word_disp(res.stub_addr, r.place);
                            if (!in_reach(d, width))
                                res.status = ST_RANGE;
                        end
                    end
                    if (res.status == ST_OK)
                    begin
                        if (r.mode == MODE_PCREL17F)
                            res.new_word = (r.old_word & ~MASK_BR17) | spread17(d);
                        else
                            res.new_word = (r.old_word & ~MASK_BR22) | spread22(d);
                    end
                end
                default:
                    res.status = ST_UNKNOWN;
            endcase
        end
        status_tally[int'(res.status)]++;
        if (res.stub_made)
            stub_tally++;
        return res;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_reloc(input reloc_t r);
        int unsigned gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        mode         <= r.mode;
        symbol_value <= r.symbol;
        addend       <= r.addend;
        place_addr   <= r.place;
        old_word     <= r.old_word;
        do @(posedge clk); while (full);
        expected_q.push_back(relocate_word(r));
    endtask

    task automatic wait_results_drained();
        push <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Caller guarantees the block is idle
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SECTION_BASE:
            begin
                base_reg = data;
                stubs_taken = '0;
            end
            REG_STUB_BUDGET:
            begin
                budget_reg = data[15:0];
                stubs_taken = '0;
            end
            REG_DATA_POINTER:
                dp_reg = data;
            default:
                ;
        endcase
    endtask

    task automatic setup_section(input logic [31:0] base, input logic [15:0] budget,
                                 input logic [31:0] dp);
        wait_results_drained();
        write_register(REG_SECTION_BASE, base);
        // upper bits of the budget write are don't-care
        write_register(REG_STUB_BUDGET, ($urandom() & 32'hffff_0000) | {16'd0, budget});
        write_register(REG_DATA_POINTER, dp);
        setup_count++;
    endtask

    function automatic reloc_t reloc(input logic [3:0] m, input logic [31:0] sym,
                                     input logic [31:0] add, input logic [31:0] place,
                                     input logic [31:0] old);
        reloc_t r;
        r.mode = m;
        r.symbol = sym;
        r.addend = add;
        r.place = place;
        r.old_word = old;
        return r;
    endfunction

    function automatic reloc_t random_reloc();
        reloc_t      r;
        logic [31:0] target;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        r = reloc(4'($urandom_range(0, 8)), $urandom(), $urandom(), $urandom(), $urandom());
        if (roll < 4)
            r.mode = 4'($urandom_range(9, 15));
        else if (roll < 8)
            r.symbol = '0;
        else if (roll < 60)
        begin
            r.mode = $urandom_range(0, 1) ? MODE_PCREL17F : MODE_PCREL22F;
            // mostly patch near the section so the stub area is within reach
            if ($urandom_range(0, 4) != 0)
                r.place = base_reg + $urandom_range(0, 32'h3ffff) - 32'h20000;
            if ($urandom_range(0, 1))
                target = r.place + $urandom_range(0, 32'h9ffff) - 32'h50000;
            else
                target = $urandom();
            if ($urandom_range(0, 1))
                r.addend = $urandom_range(0, 32'hfff) - 32'h800;
            r.symbol = target - r.addend;
            if (r.symbol == 32'd0)
                r.symbol = 32'd1;
        end
        return r;
    endfunction

    // ---------------- result side ----------------

    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            pop <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_hold_req)
        begin
            rx_hold_req = 1'b0;
            rx_hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            pop <= 1'b0;
            rx_stall_left--;
        end
        else if (rx_idle_en && $urandom_range(0, 99) < 30)
        begin
            rx_stall_left = pick_gap();
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing pending, new_word %h", new_word);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("new_word", want.new_word, new_word);
                check_field("stub_made", 32'(want.stub_made), 32'(stub_made));
                check_field("stub_addr", want.stub_addr, stub_addr);
                check_field("stub_word_first", want.stub_word_first, stub_word_first);
                check_field("stub_word_second", want.stub_word_second, stub_word_second);
                check_field("status", 32'(want.status), 32'(status));
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        // budget is zero out of reset, so any far branch runs out of stubs
        send_reloc(reloc(MODE_DIR32, 32'h0000_0001, 32'hffff_ffff, 32'h0, 32'h1234_5678));
        send_reloc(reloc(MODE_PCREL17F, 32'h8000_0000, 32'h0, 32'h0000_1000, 32'hffff_ffff));
    endtask

    task automatic test_absolute_modes();
        send_reloc(reloc(MODE_PLABEL32, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h0));
        send_reloc(reloc(MODE_DIR32, 32'h0000_0001, 32'h8000_0000, 32'h0, 32'hffff_ffff));
        send_reloc(reloc(MODE_SEGREL32, 32'h8000_0000, 32'hffff_ffff, 32'h4, 32'ha5a5_a5a5));
    endtask

    task automatic test_split_fields();
        wait_results_drained();
        write_register(REG_DATA_POINTER, 32'h1234_5678);
        // addends on both sides of the rounding point
        send_reloc(reloc(MODE_DIR21L, 32'hffff_ffff, 32'h0000_0fff, 32'h0, 32'h0));
        send_reloc(reloc(MODE_DIR21L, 32'h0000_0800, 32'h0000_1000, 32'h0, 32'hffff_ffff));
        send_reloc(reloc(MODE_DIR14R, 32'h1234_5fff, 32'h0000_1000, 32'h0, 32'hffff_ffff));
        send_reloc(reloc(MODE_DIR14R, 32'h0000_0001, 32'hffff_efff, 32'h0, 32'h0));
        send_reloc(reloc(MODE_DPREL21L, 32'h1234_5678, 32'h7fff_ffff, 32'h0, 32'h5a5a_5a5a));
        send_reloc(reloc(MODE_DPREL14R, 32'h0000_0001, 32'h8000_0000, 32'h0, 32'ha5a5_a5a5));
    endtask

    task automatic test_branches();
        setup_section(32'h0010_0000, 16'd2, 32'h1234_5678);
        send_reloc(reloc(MODE_PCREL17F, 32'h0010_0100, 32'h0, 32'h0010_0000, 32'hffff_ffff));
        send_reloc(reloc(MODE_PCREL22F, 32'h0008_0000, 32'h0, 32'h0010_0003, 32'h0));
        send_reloc(reloc(MODE_PCREL17F, 32'h8000_0000, 32'h123, 32'h0010_0010, 32'h0));
        send_reloc(reloc(MODE_PCREL22F, 32'h4000_0000, 32'hffff_fffc, 32'h0010_0020,
                         32'hffff_ffff));
        // both slots taken
        send_reloc(reloc(MODE_PCREL17F, 32'h9000_0000, 32'h0, 32'h0010_0030, 32'h1111_1111));
        wait_results_drained();
        write_register(REG_STUB_BUDGET, 32'd3);
        // slot taken but the stub itself is out of reach
        send_reloc(reloc(MODE_PCREL17F, 32'h8000_0000, 32'h0, 32'hf000_0000, 32'h2222_2222));
        // edges of the 22-bit reach
        send_reloc(reloc(MODE_PCREL22F, 32'h0090_0004, 32'h0, 32'h0010_0000, 32'h0));
        send_reloc(reloc(MODE_PCREL22F, 32'h0090_0008, 32'h0, 32'h0010_0000, 32'h0));
        send_reloc(reloc(MODE_PCREL22F, 32'hff90_0008, 32'h0, 32'h0010_0000, 32'hffff_ffff));
    endtask

    task automatic test_undefined_and_unknown();
        send_reloc(reloc(MODE_DIR32, 32'h0, 32'h1000, 32'h0, 32'hdead_beef));
        send_reloc(reloc(MODE_PCREL22F, 32'h0, 32'h8000_0000, 32'h0010_0000, 32'hcafe_f00d));
        send_reloc(reloc(4'd9, 32'h0000_1000, 32'h0, 32'h0, 32'h0f0f_0f0f));
        send_reloc(reloc(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    endtask

    task automatic test_register_index();
        setup_section(32'h2000_0000, 16'd4, 32'h0);
        send_reloc(reloc(MODE_PCREL22F, 32'h0000_0100, 32'h0, 32'h2000_0000, 32'h0));
        wait_results_drained();
        // neither of these may clear the slot counter
        write_register(REG_RESERVED, 32'hffff_ffff);
        write_register(REG_DATA_POINTER, 32'hffff_ffff);
        send_reloc(reloc(MODE_PCREL22F, 32'h0000_0200, 32'h0, 32'h2000_0004, 32'hffff_ffff));
    endtask

    task automatic test_backpressure();
        setup_section(32'h0040_0000, 16'd8, $urandom());
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_req = 1'b1;
        repeat (40) send_reloc(random_reloc());
        // sender pauses until every word is back
        wait_results_drained();
        repeat (40) send_reloc(random_reloc());
    endtask

    task automatic test_random_sections();
        logic [31:0] base;
        logic [15:0] budget;
        for (int phase = 0; phase < 6; phase++)
        begin
            base = $urandom();
            case ($urandom_range(0, 3))
                0: budget = 16'd0;
                1: budget = 16'($urandom_range(1, 8));
                2: budget = 16'hffff;
                default: budget = 16'($urandom());
            endcase
            if (phase == 0)
                setup_section(32'hffff_ffff, 16'hffff, 32'h0);
            else if (phase == 1)
                setup_section(32'h0, 16'd0, 32'hffff_ffff);
            else
                setup_section(base, budget, $urandom());
            for (int n = 0; n < 230; n++)
            begin
                if (n % 50 == 0)
                begin
                    tx_idle_en = ($urandom_range(0, 3) != 0);
                    rx_idle_en = ($urandom_range(0, 3) != 0);
                end
                send_reloc(random_reloc());
            end
        end
    endtask

    initial
    begin
        base_reg = '0;
        budget_reg = '0;
        dp_reg = '0;
        stubs_taken = '0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_absolute_modes();
        test_split_fields();
        test_branches();
        test_undefined_and_unknown();
        test_register_index();
        test_backpressure();
        test_random_sections();
        wait_results_drained();

        $display("Relocations: %0d ok, %0d undefined, %0d out of range, %0d unknown, %0d no stub",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        $display("Long-branch stubs allocated: %0d across %0d section setups",
                 stub_tally, setup_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
